FILE: src/hcr_pkg.sv
// ----------------------------------------------------------------------------
// hcr_pkg
// Shared types and constants of the height to colour ramp unit: field widths,
// fixed point format, ramp colour stops, point classes and the queue entry.
// ----------------------------------------------------------------------------
package hcr_pkg;

  // field widths
  localparam int HEIGHT_W   = 32;
  localparam int COLOR_W    = 24;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // differences of two heights need one extra bit, their magnitude does not
  localparam int NUM_W = HEIGHT_W + 1;
  localparam int MAG_W = HEIGHT_W;

  // unsigned q1.f ratio and segment position
  localparam int RATIO_FRAC_BITS = 16;
  localparam int RATIO_W         = RATIO_FRAC_BITS + 1;
  localparam logic [RATIO_W-1:0] RATIO_ONE  = RATIO_W'(1) << RATIO_FRAC_BITS;
  localparam logic [RATIO_W-1:0] RATIO_HALF = RATIO_W'(1) << (RATIO_FRAC_BITS - 1);

  // blend accumulator: channel start, signed difference times position
  localparam int PROD_W = CH_W + 1 + RATIO_W + 1;

  // decoupling queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HEIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HEIGHT = 1'b1;

  // ramp stops, red first
  localparam logic [CH_W-1:0] STOP_LO  [NUM_CH] = '{8'd80,  8'd70,  8'd200};
  localparam logic [CH_W-1:0] STOP_MID [NUM_CH] = '{8'd140, 8'd120, 8'd180};
  localparam logic [CH_W-1:0] STOP_HI  [NUM_CH] = '{8'd255, 8'd140, 8'd120};

  // how a point gets its colour
  typedef enum logic [2:0] {
    CLS_PASS,   // colour given with the point
    CLS_ZERO,   // ratio is zero
    CLS_HALF,   // equal bounds
    CLS_ONE,    // ratio saturates at one
    CLS_DIV     // ratio needs the divider
  } hcr_cls_t;

  // entry handed from the front to the back
  typedef struct packed {
    hcr_cls_t           cls;
    logic [MAG_W-1:0]   an;
    logic [MAG_W-1:0]   ad;
    logic [COLOR_W-1:0] color;
    logic               last;
  } hcr_entry_t;

  // one divider pipeline stage
  typedef struct packed {
    hcr_cls_t                   cls;
    logic [MAG_W-1:0]           rem;
    logic [MAG_W-1:0]           ad;
    logic [RATIO_FRAC_BITS-1:0] q;
    logic [COLOR_W-1:0]         color;
    logic                       last;
  } hcr_stage_t;

endpackage

FILE: src/hcr_front.sv
// ----------------------------------------------------------------------------
// hcr_front
// Holds the height bounds, takes in points, forms the height differences and
// sorts each point into a class before handing it to the queue.
// ----------------------------------------------------------------------------
module hcr_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hcr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [hcr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [hcr_pkg::HEIGHT_W-1:0]   in_height,
  input  logic                           in_has_color,
  input  logic [hcr_pkg::COLOR_W-1:0]    in_given_color,
  input  logic                           in_last_point,
  output logic                           push,
  input  logic                           push_ready,
  output hcr_pkg::hcr_entry_t            push_entry
);
  import hcr_pkg::*;

  logic [HEIGHT_W-1:0] min_height_r;
  logic [HEIGHT_W-1:0] max_height_r;
  logic                front_v_r;
  logic [NUM_W-1:0]    num_r;
  logic [NUM_W-1:0]    den_r;
  logic                has_color_r;
  logic [COLOR_W-1:0]  color_r;
  logic                last_r;
  logic [NUM_W-1:0]    num_nxt;
  logic [NUM_W-1:0]    den_nxt;
  logic [NUM_W-1:0]    neg_num;
  logic [NUM_W-1:0]    neg_den;
  logic                in_xfer;

  // bounds registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_height_r <= '0;
      max_height_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MIN_HEIGHT: min_height_r <= cfg_wdata[HEIGHT_W-1:0];
        REG_MAX_HEIGHT: max_height_r <= cfg_wdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // signed differences against the lower bound
  assign num_nxt = {in_height[HEIGHT_W-1], in_height}
                 - {min_height_r[HEIGHT_W-1], min_height_r};
  assign den_nxt = {max_height_r[HEIGHT_W-1], max_height_r}
                 - {min_height_r[HEIGHT_W-1], min_height_r};

  assign in_ready = !front_v_r || push_ready;
  assign in_xfer  = in_valid && in_ready;
  assign push     = front_v_r && push_ready;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else if (in_ready) begin
      front_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      num_r       <= num_nxt;
      den_r       <= den_nxt;
      has_color_r <= in_has_color;
      color_r     <= in_given_color;
      last_r      <= in_last_point;
    end
  end

  // magnitudes and class
  assign neg_num = -num_r;
  assign neg_den = -den_r;

  always_comb begin
    push_entry.an    = num_r[NUM_W-1] ? neg_num[MAG_W-1:0] : num_r[MAG_W-1:0];
    push_entry.ad    = den_r[NUM_W-1] ? neg_den[MAG_W-1:0] : den_r[MAG_W-1:0];
    push_entry.color = color_r;
    push_entry.last  = last_r;
    if (has_color_r) begin
      push_entry.cls = CLS_PASS;
    end else if (den_r == '0) begin
      push_entry.cls = CLS_HALF;
    end else if (num_r == '0 || (num_r[NUM_W-1] != den_r[NUM_W-1])) begin
      push_entry.cls = CLS_ZERO;
    end else begin
      push_entry.cls = CLS_DIV;
    end
  end

endmodule

FILE: src/hcr_queue.sv
// ----------------------------------------------------------------------------
// hcr_queue
// Small first-in first-out queue of classified points between the front and
// the back, so that either side can stall without holding up the other.
// ----------------------------------------------------------------------------
module hcr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                push_ready,
  input  hcr_pkg::hcr_entry_t push_entry,
  input  logic                pop,
  output logic                pop_valid,
  output hcr_pkg::hcr_entry_t pop_entry
);
  import hcr_pkg::*;

  hcr_entry_t             slot_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] count_r;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = count_r != QUEUE_CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_entry  = slot_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_entry;
  end

endmodule

FILE: src/hcr_back.sv
// ----------------------------------------------------------------------------
// hcr_back
// Takes classified points from the queue, finds the ratio with a pipelined
// restoring divider (one quotient bit a stage), picks the ramp segment and
// blends the three channels into the output register.
// ----------------------------------------------------------------------------
module hcr_back (
  input  logic                         clk,
  input  logic                         rst_n,
  output logic                         pop,
  input  logic                         pop_valid,
  input  hcr_pkg::hcr_entry_t          pop_entry,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hcr_pkg::COLOR_W-1:0]  out_color,
  output logic                         out_last_color
);
  import hcr_pkg::*;

  localparam int NSTG = RATIO_FRAC_BITS + 1;

  logic                   adv;
  logic                   stg_v_r [NSTG];
  hcr_stage_t             stg_r   [NSTG];
  hcr_stage_t             stg0_nxt;

  logic                   rp_v_r;
  logic                   rp_pass_r;
  logic                   rp_seg_r;
  logic [RATIO_W-1:0]     rp_t_r;
  logic [COLOR_W-1:0]     rp_color_r;
  logic                   rp_last_r;
  logic [RATIO_W-1:0]     ratio;
  logic [RATIO_W:0]       ratio_x2;
  logic                   seg_nxt;
  logic [RATIO_W-1:0]     t_nxt;

  logic                   out_valid_r;
  logic [COLOR_W-1:0]     out_color_r;
  logic                   out_last_r;
  logic [COLOR_W-1:0]     color_nxt;

  // the whole pipeline moves when the output register is free
  assign adv = !out_valid_r || out_ready;
  assign pop = adv && pop_valid;

  // stage 0: saturation check, divider set-up
  always_comb begin
    stg0_nxt.cls   = pop_entry.cls;
    stg0_nxt.rem   = pop_entry.an;
    stg0_nxt.ad    = pop_entry.ad;
    stg0_nxt.q     = '0;
    stg0_nxt.color = pop_entry.color;
    stg0_nxt.last  = pop_entry.last;
    if (pop_entry.cls == CLS_DIV && pop_entry.an >= pop_entry.ad) begin
      stg0_nxt.cls = CLS_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r[0] <= 1'b0;
    end else if (adv) begin
      stg_v_r[0] <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) stg_r[0] <= stg0_nxt;
  end

  // divider stages, one quotient bit each
  for (genvar k = 1; k < NSTG; k++) begin : g_div
    logic [MAG_W:0]   shl;
    logic             fits;
    logic [MAG_W:0]   diff;
    hcr_stage_t       nxt;

    assign shl  = {stg_r[k-1].rem, 1'b0};
    assign fits = shl >= {1'b0, stg_r[k-1].ad};
    assign diff = shl - {1'b0, stg_r[k-1].ad};

    always_comb begin
      nxt     = stg_r[k-1];
      nxt.rem = fits ? diff[MAG_W-1:0] : shl[MAG_W-1:0];
      nxt.q   = {stg_r[k-1].q[RATIO_FRAC_BITS-2:0], fits};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_v_r[k] <= 1'b0;
      end else if (adv) begin
        stg_v_r[k] <= stg_v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) stg_r[k] <= nxt;
    end
  end

  // ratio from class, then segment and position
  always_comb begin
    case (stg_r[NSTG-1].cls)
      CLS_HALF: ratio = RATIO_HALF;
      CLS_ONE:  ratio = RATIO_ONE;
      CLS_DIV:  ratio = {1'b0, stg_r[NSTG-1].q};
      default:  ratio = '0;
    endcase
    ratio_x2 = {ratio, 1'b0};
    seg_nxt  = ratio > RATIO_HALF;
    if (seg_nxt) begin
      t_nxt = RATIO_W'(ratio_x2 - {1'b0, RATIO_ONE});
    end else begin
      t_nxt = ratio_x2[RATIO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_v_r <= 1'b0;
    end else if (adv) begin
      rp_v_r <= stg_v_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rp_pass_r  <= stg_r[NSTG-1].cls == CLS_PASS;
      rp_seg_r   <= seg_nxt;
      rp_t_r     <= t_nxt;
      rp_color_r <= stg_r[NSTG-1].color;
      rp_last_r  <= stg_r[NSTG-1].last;
    end
  end

  // per channel blend: start + (end - start) * t, integer part
  always_comb begin
    logic [CH_W-1:0]          c_start;
    logic [CH_W-1:0]          c_end;
    logic signed [CH_W:0]     c_diff;
    logic signed [PROD_W-1:0] diff_x;
    logic signed [PROD_W-1:0] t_x;
    logic signed [PROD_W-1:0] base_x;
    logic signed [PROD_W-1:0] acc;
    logic [CH_W-1:0]          ch [NUM_CH];
    for (int c = 0; c < NUM_CH; c++) begin
      c_start = rp_seg_r ? STOP_MID[c] : STOP_LO[c];
      c_end   = rp_seg_r ? STOP_HI[c]  : STOP_MID[c];
      c_diff  = $signed({1'b0, c_end}) - $signed({1'b0, c_start});
      diff_x  = PROD_W'(c_diff);
      t_x     = PROD_W'({1'b0, rp_t_r});
      base_x  = PROD_W'({1'b0, c_start}) << RATIO_FRAC_BITS;
      acc     = base_x + diff_x * t_x;
      ch[c]   = acc[RATIO_FRAC_BITS +: CH_W];
    end
    color_nxt = rp_pass_r ? rp_color_r : {ch[0], ch[1], ch[2]};
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= rp_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_color_r <= color_nxt;
      out_last_r  <= rp_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_color      = out_color_r;
  assign out_last_color = out_last_r;

endmodule

FILE: src/height_to_color_ramp_unit.sv
// ----------------------------------------------------------------------------
// height_to_color_ramp_unit
// One point per cycle sustained while out_ready does not stall the output,
// carried through the 16-stage divider pipeline.
// Synchronous active-low reset clears both bounds to zero and empties the unit.
// ----------------------------------------------------------------------------
module height_to_color_ramp_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hcr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [hcr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [hcr_pkg::HEIGHT_W-1:0]   in_height,
  input  logic                           in_has_color,
  input  logic [hcr_pkg::COLOR_W-1:0]    in_given_color,
  input  logic                           in_last_point,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [hcr_pkg::COLOR_W-1:0]    out_color,
  output logic                           out_last_color
);
  import hcr_pkg::*;

  logic       push;
  logic       push_ready;
  hcr_entry_t push_entry;
  logic       pop;
  logic       pop_valid;
  hcr_entry_t pop_entry;

  // classify points
  hcr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_height      (in_height),
    .in_has_color   (in_has_color),
    .in_given_color (in_given_color),
    .in_last_point  (in_last_point),
    .push           (push),
    .push_ready     (push_ready),
    .push_entry     (push_entry)
  );

  // decoupling queue
  hcr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry)
  );

  // ratio and colour
  hcr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop            (pop),
    .pop_valid      (pop_valid),
    .pop_entry      (pop_entry),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_color      (out_color),
    .out_last_color (out_last_color)
  );

endmodule
